[rtl/core/pfspec_pkg.sv]
// ----------------------------------------------------------------------------
// pfspec_pkg
// Shared types and codes for the printf conversion specification parser:
// parse phases, accumulator record, length kinds and character codes.
// ----------------------------------------------------------------------------
package pfspec_pkg;

    // Parse phase, one-hot
    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_FLAGS   = 8'b0000_0010,
        PH_WIDTH   = 8'b0000_0100,
        PH_WSTAR   = 8'b0000_1000,
        PH_PSTART  = 8'b0001_0000,
        PH_PDIGITS = 8'b0010_0000,
        PH_MOD     = 8'b0100_0000,
        PH_SUFFIX  = 8'b1000_0000
    } phase_t;

    // Justification codes
    localparam logic [1:0] J_LEFT  = 2'd0;
    localparam logic [1:0] J_RIGHT = 2'd1;
    localparam logic [1:0] J_ZERO  = 2'd2;

    // Sign codes
    localparam logic [1:0] S_MINUS = 2'd0;
    localparam logic [1:0] S_PLUS  = 2'd1;
    localparam logic [1:0] S_SPACE = 2'd2;

    // Length kinds
    localparam logic [3:0] L_NORMAL  = 4'd0;
    localparam logic [3:0] L_CHAR    = 4'd1;
    localparam logic [3:0] L_SHORT   = 4'd2;
    localparam logic [3:0] L_LONG    = 4'd3;
    localparam logic [3:0] L_LLONG   = 4'd4;
    localparam logic [3:0] L_WIDE    = 4'd5;
    localparam logic [3:0] L_INTMAX  = 4'd6;
    localparam logic [3:0] L_SIZE    = 4'd7;
    localparam logic [3:0] L_PTRDIFF = 4'd8;
    localparam logic [3:0] L_LDOUBLE = 4'd9;

    // Limits and defaults
    localparam logic [7:0]  BAD_CONV     = 8'hFF;
    localparam logic [30:0] S_WIDTH_MAX  = 31'd509;
    localparam logic [31:0] PREC_INT     = 32'd1;
    localparam logic [31:0] PREC_FLOAT   = 32'd6;
    localparam logic [31:0] PREC_HEX     = 32'hD;
    localparam logic [31:0] PREC_PTR     = 32'd8;

    // Character codes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LO_H    = 8'h68;
    localparam logic [7:0] CH_LO_L    = 8'h6C;
    localparam logic [7:0] CH_UP_L    = 8'h4C;
    localparam logic [7:0] CH_LO_J    = 8'h6A;
    localparam logic [7:0] CH_LO_T    = 8'h74;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_LO_D    = 8'h64;
    localparam logic [7:0] CH_LO_I    = 8'h69;
    localparam logic [7:0] CH_LO_U    = 8'h75;
    localparam logic [7:0] CH_LO_O    = 8'h6F;
    localparam logic [7:0] CH_LO_X    = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_LO_G    = 8'h67;
    localparam logic [7:0] CH_UP_G    = 8'h47;
    localparam logic [7:0] CH_LO_E    = 8'h65;
    localparam logic [7:0] CH_UP_E    = 8'h45;
    localparam logic [7:0] CH_LO_P    = 8'h70;
    localparam logic [7:0] CH_LO_C    = 8'h63;
    localparam logic [7:0] CH_LO_S    = 8'h73;
    localparam logic [7:0] CH_LO_N    = 8'h6E;

    // Fields collected for the open specification
    typedef struct packed {
        logic [1:0]  justify;
        logic [1:0]  sign;
        logic        prec_given;
        logic        alternate;
        logic [3:0]  length;
        logic [30:0] width;
        logic [31:0] precision;
    } acc_t;

    localparam acc_t ACC_CLEAR = '{
        justify:    J_RIGHT,
        sign:       S_MINUS,
        prec_given: 1'b0,
        alternate:  1'b0,
        length:     L_NORMAL,
        width:      31'd0,
        precision:  32'd0
    };

    // One emitted record
    typedef struct packed {
        acc_t       fields;
        logic [7:0] conversion;
    } rec_t;

endpackage

[rtl/core/pfspec_step.sv]
// ----------------------------------------------------------------------------
// pfspec_step
// Next-state and record logic for one specification byte: flag decode,
// decimal accumulate with 31-bit overflow check, star handling, length
// modifiers and final validation of the conversion letter.
// ----------------------------------------------------------------------------
module pfspec_step (
    input  logic               start_req,
    input  logic [7:0]         ch,
    input  logic [31:0]        star,
    input  pfspec_pkg::phase_t phase,
    input  pfspec_pkg::acc_t   acc,
    output pfspec_pkg::phase_t phase_next,
    output pfspec_pkg::acc_t   acc_next,
    output logic               emit,
    output logic [7:0]         conversion
);

    logic        is_digit;
    logic [3:0]  digit;
    logic [30:0] dec_src;
    logic [34:0] dec_sum;
    logic        dec_ovf;
    logic [31:0] star_neg;
    logic        go_flags;
    logic        go_after;
    logic        go_len;
    logic        go_fin;
    logic        int_mod_bad;
    logic        is_fmt;

    assign is_digit = (ch >= pfspec_pkg::CH_ZERO) && (ch <= pfspec_pkg::CH_NINE);
    assign digit    = 4'(ch - pfspec_pkg::CH_ZERO);
    assign star_neg = 32'd0 - star;

    // Shift-add times ten plus digit; the source is whichever field is open
    assign dec_src = (phase == pfspec_pkg::PH_PDIGITS) ? acc.precision[30:0] : acc.width;
    assign dec_sum = ({4'd0, dec_src} << 3) + ({4'd0, dec_src} << 1) + {31'd0, digit};
    assign dec_ovf = (dec_sum[34:31] != 4'd0);

    always_comb
    begin
        phase_next = phase;
        acc_next   = acc;
        emit       = 1'b0;
        conversion = pfspec_pkg::BAD_CONV;
        go_flags   = 1'b0;
        go_after   = 1'b0;
        go_len     = 1'b0;
        go_fin     = 1'b0;
        int_mod_bad = 1'b0;
        is_fmt     = 1'b0;

        // Dispatch on start or current phase
        if (start_req)
        begin
            acc_next   = pfspec_pkg::ACC_CLEAR;
            phase_next = pfspec_pkg::PH_FLAGS;
            if (ch == pfspec_pkg::CH_PERCENT)
            begin
                emit       = 1'b1;
                conversion = pfspec_pkg::CH_PERCENT;
            end
            else
            begin
                go_flags = 1'b1;
            end
        end
        else
        begin
            unique case (phase)
                pfspec_pkg::PH_IDLE:
                begin
                end
                pfspec_pkg::PH_FLAGS:
                begin
                    go_flags = 1'b1;
                end
                pfspec_pkg::PH_WIDTH:
                begin
                    if (is_digit)
                    begin
                        if (dec_ovf)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            acc_next.width = dec_sum[30:0];
                        end
                    end
                    else
                    begin
                        go_after = 1'b1;
                    end
                end
                pfspec_pkg::PH_WSTAR:
                begin
                    go_after = 1'b1;
                end
                pfspec_pkg::PH_PSTART:
                begin
                    if (ch == pfspec_pkg::CH_STAR)
                    begin
                        acc_next.precision = star;
                        if (star[31])
                        begin
                            acc_next.prec_given = 1'b0;
                        end
                        phase_next = pfspec_pkg::PH_MOD;
                    end
                    else if (is_digit)
                    begin
                        acc_next.precision = {28'd0, digit};
                        phase_next = pfspec_pkg::PH_PDIGITS;
                    end
                    else
                    begin
                        go_len = 1'b1;
                    end
                end
                pfspec_pkg::PH_PDIGITS:
                begin
                    if (is_digit)
                    begin
                        if (dec_ovf)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            acc_next.precision = {1'b0, dec_sum[30:0]};
                        end
                    end
                    else
                    begin
                        go_len = 1'b1;
                    end
                end
                pfspec_pkg::PH_MOD:
                begin
                    go_len = 1'b1;
                end
                pfspec_pkg::PH_SUFFIX:
                begin
                    if (ch == pfspec_pkg::CH_LO_H && acc.length == pfspec_pkg::L_SHORT)
                    begin
                        acc_next.length = pfspec_pkg::L_CHAR;
                    end
                    else if (ch == pfspec_pkg::CH_LO_L && acc.length == pfspec_pkg::L_LONG)
                    begin
                        acc_next.length = pfspec_pkg::L_LLONG;
                    end
                    else
                    begin
                        go_fin = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Flags, star width or first width digit
        if (go_flags)
        begin
            priority if (ch == pfspec_pkg::CH_MINUS)
            begin
                acc_next.justify = pfspec_pkg::J_LEFT;
            end
            else if (ch == pfspec_pkg::CH_PLUS)
            begin
                acc_next.sign = pfspec_pkg::S_PLUS;
            end
            else if (ch == pfspec_pkg::CH_SPACE)
            begin
                if (acc_next.sign != pfspec_pkg::S_PLUS)
                begin
                    acc_next.sign = pfspec_pkg::S_SPACE;
                end
            end
            else if (ch == pfspec_pkg::CH_HASH)
            begin
                acc_next.alternate = 1'b1;
            end
            else if (ch == pfspec_pkg::CH_ZERO)
            begin
                if (acc_next.justify != pfspec_pkg::J_LEFT)
                begin
                    acc_next.justify = pfspec_pkg::J_ZERO;
                end
            end
            else if (ch == pfspec_pkg::CH_STAR)
            begin
                if (star == 32'h8000_0000)
                begin
                    acc_next.width = 31'd0;
                    emit = 1'b1;
                end
                else if (star[31])
                begin
                    acc_next.justify = pfspec_pkg::J_LEFT;
                    acc_next.width   = star_neg[30:0];
                    phase_next       = pfspec_pkg::PH_WSTAR;
                end
                else
                begin
                    acc_next.width = star[30:0];
                    phase_next     = pfspec_pkg::PH_WSTAR;
                end
            end
            else if (is_digit)
            begin
                acc_next.width = {27'd0, digit};
                phase_next     = pfspec_pkg::PH_WIDTH;
            end
            else
            begin
                go_after = 1'b1;
            end
        end

        // Precision dot, or fall through to the length modifier
        if (go_after)
        begin
            if (ch == pfspec_pkg::CH_DOT)
            begin
                acc_next.prec_given = 1'b1;
                phase_next = pfspec_pkg::PH_PSTART;
            end
            else
            begin
                go_len = 1'b1;
            end
        end

        // Length modifier, or fall through to the conversion letter
        if (go_len)
        begin
            phase_next = pfspec_pkg::PH_SUFFIX;
            priority if (ch == pfspec_pkg::CH_LO_H)
            begin
                acc_next.length = pfspec_pkg::L_SHORT;
            end
            else if (ch == pfspec_pkg::CH_LO_L)
            begin
                acc_next.length = pfspec_pkg::L_LONG;
            end
            else if (ch == pfspec_pkg::CH_UP_L)
            begin
                acc_next.length = pfspec_pkg::L_LDOUBLE;
            end
            else if (ch == pfspec_pkg::CH_LO_J)
            begin
                acc_next.length = pfspec_pkg::L_INTMAX;
            end
            else if (ch == pfspec_pkg::CH_LO_T)
            begin
                acc_next.length = pfspec_pkg::L_PTRDIFF;
            end
            else if (ch == pfspec_pkg::CH_LO_Z)
            begin
                acc_next.length = pfspec_pkg::L_SIZE;
            end
            else
            begin
                phase_next = phase;
                go_fin     = 1'b1;
            end
        end

        // Validate the conversion letter and apply defaults
        if (go_fin)
        begin
            emit       = 1'b1;
            conversion = ch;
            int_mod_bad = (acc_next.length == pfspec_pkg::L_SHORT)
                       || (acc_next.length == pfspec_pkg::L_INTMAX)
                       || (acc_next.length == pfspec_pkg::L_SIZE)
                       || (acc_next.length == pfspec_pkg::L_PTRDIFF)
                       || (acc_next.length == pfspec_pkg::L_LLONG);
            is_fmt = (ch == pfspec_pkg::CH_LO_G) || (ch == pfspec_pkg::CH_UP_G);
            priority if (ch == pfspec_pkg::CH_LO_D || ch == pfspec_pkg::CH_LO_I
                      || ch == pfspec_pkg::CH_LO_U || ch == pfspec_pkg::CH_LO_O
                      || ch == pfspec_pkg::CH_LO_X || ch == pfspec_pkg::CH_UP_X)
            begin
                if (acc_next.length == pfspec_pkg::L_LDOUBLE)
                begin
                    conversion = pfspec_pkg::BAD_CONV;
                end
                else if (!acc_next.prec_given)
                begin
                    acc_next.precision = pfspec_pkg::PREC_INT;
                end
                else if (acc_next.justify == pfspec_pkg::J_ZERO)
                begin
                    acc_next.justify = pfspec_pkg::J_RIGHT;
                end
            end
            else if (ch == pfspec_pkg::CH_LO_F || ch == pfspec_pkg::CH_UP_F)
            begin
                if (int_mod_bad)
                begin
                    conversion = pfspec_pkg::BAD_CONV;
                end
                else if (!acc_next.prec_given)
                begin
                    acc_next.precision = pfspec_pkg::PREC_FLOAT;
                end
            end
            else if (ch == pfspec_pkg::CH_LO_A || ch == pfspec_pkg::CH_UP_A)
            begin
                if (!acc_next.prec_given)
                begin
                    acc_next.precision = pfspec_pkg::PREC_HEX;
                end
                if (int_mod_bad || acc_next.length == pfspec_pkg::L_CHAR)
                begin
                    conversion = pfspec_pkg::BAD_CONV;
                end
            end
            else if (is_fmt || ch == pfspec_pkg::CH_LO_E || ch == pfspec_pkg::CH_UP_E)
            begin
                // g with a zero precision means one digit
                if (is_fmt && acc_next.precision == 32'd0)
                begin
                    acc_next.precision = 32'd1;
                end
                if (int_mod_bad || acc_next.length == pfspec_pkg::L_CHAR)
                begin
                    conversion = pfspec_pkg::BAD_CONV;
                end
                else if (!acc_next.prec_given)
                begin
                    acc_next.precision = pfspec_pkg::PREC_FLOAT;
                end
            end
            else if (ch == pfspec_pkg::CH_LO_P)
            begin
                // Pointer prints as alternate-form long hex
                conversion         = pfspec_pkg::CH_LO_X;
                acc_next.alternate = 1'b1;
                acc_next.length    = pfspec_pkg::L_LONG;
                acc_next.precision = pfspec_pkg::PREC_PTR;
            end
            else if (ch == pfspec_pkg::CH_LO_C)
            begin
                if (acc_next.length == pfspec_pkg::L_LONG)
                begin
                    acc_next.length = pfspec_pkg::L_WIDE;
                end
                else if (acc_next.prec_given || acc_next.length != pfspec_pkg::L_NORMAL)
                begin
                    conversion = pfspec_pkg::BAD_CONV;
                end
            end
            else if (ch == pfspec_pkg::CH_LO_S)
            begin
                if (acc_next.length == pfspec_pkg::L_LONG)
                begin
                    acc_next.length = pfspec_pkg::L_WIDE;
                end
                else if (acc_next.length != pfspec_pkg::L_NORMAL)
                begin
                    conversion = pfspec_pkg::BAD_CONV;
                end
            end
            else if (ch == pfspec_pkg::CH_LO_N)
            begin
                if (acc_next.length == pfspec_pkg::L_LDOUBLE)
                begin
                    conversion = pfspec_pkg::BAD_CONV;
                end
            end
            else
            begin
                conversion = pfspec_pkg::BAD_CONV;
            end

            // Strings have a bounded field width
            if (conversion == pfspec_pkg::CH_LO_S && acc_next.width > pfspec_pkg::S_WIDTH_MAX)
            begin
                conversion = pfspec_pkg::BAD_CONV;
            end
        end

        // A record closes the specification
        if (emit)
        begin
            phase_next = pfspec_pkg::PH_IDLE;
        end
    end

endmodule

[rtl/core/printf_spec_parser_top.sv]
// ----------------------------------------------------------------------------
// printf_spec_parser_top
// Parses printf conversion specifications one byte per item and emits one
// record per completed (or rejected) specification.
// ----------------------------------------------------------------------------
// Pipeline: the input register, then decode into the result register and the
//   parse state.
// Throughput: one byte per cycle unless out_ready stalls the result register;
//   the single decode stage with its times-ten shift-add sets the cycle.
// Reset: rst_n clears the parse phase to idle, the accumulators to defaults
//   and both valid flags; bytes are accepted once reset is released.
// ----------------------------------------------------------------------------
module printf_spec_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_req,
    input  logic [7:0]  character,
    input  logic signed [31:0] star_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  justify_mode,
    output logic [1:0]  sign_mode,
    output logic        precision_given,
    output logic        alternate,
    output logic [3:0]  length_kind,
    output logic [7:0]  conversion,
    output logic [30:0] width,
    output logic signed [31:0] precision_value
);

    logic               s1_valid_reg;
    logic               s1_start_reg;
    logic [7:0]         s1_char_reg;
    logic [31:0]        s1_star_reg;
    pfspec_pkg::phase_t phase_reg;
    pfspec_pkg::phase_t phase_next;
    pfspec_pkg::acc_t   acc_reg;
    pfspec_pkg::acc_t   acc_next;
    pfspec_pkg::rec_t   rec_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               step_emit;
    logic [7:0]         step_conv;
    logic               s2_take;
    logic               in_take;

    // Advance stage one when the result register is free or draining
    assign s2_take  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_take;
    assign in_take  = in_valid && in_ready;

    // Hold the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_start_reg <= start_req;
            s1_char_reg  <= character;
            s1_star_reg  <= star_value;
        end
    end

    pfspec_step u_step (
        .start_req  (s1_start_reg),
        .ch         (s1_char_reg),
        .star       (s1_star_reg),
        .phase      (phase_reg),
        .acc        (acc_reg),
        .phase_next (phase_next),
        .acc_next   (acc_next),
        .emit       (step_emit),
        .conversion (step_conv)
    );

    // Advance the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pfspec_pkg::PH_IDLE;
            acc_reg   <= pfspec_pkg::ACC_CLEAR;
        end
        else if (s2_take)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
        end
    end

    // Result register
    assign out_valid_next = (out_valid_reg && !out_ready) || (s2_take && step_emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_take && step_emit)
        begin
            rec_reg.fields     <= acc_next;
            rec_reg.conversion <= step_conv;
        end
    end

    // Drive the result ports
    assign out_valid       = out_valid_reg;
    assign justify_mode    = rec_reg.fields.justify;
    assign sign_mode       = rec_reg.fields.sign;
    assign precision_given = rec_reg.fields.prec_given;
    assign alternate       = rec_reg.fields.alternate;
    assign length_kind     = rec_reg.fields.length;
    assign conversion      = rec_reg.conversion;
    assign width           = rec_reg.fields.width;
    assign precision_value = rec_reg.fields.precision;

`ifndef SYNTHESIS
    // A stalled result must also stall the held input item
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && s1_valid_reg) |-> !in_ready)
        else $error("input stage advanced into a stalled result");

    // Every emitted record closes the specification
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_take && step_emit) |=> (phase_reg == pfspec_pkg::PH_IDLE))
        else $error("parse phase not idle after a record");

    // An accepted string conversion respects the width bound
    a_s_width: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rec_reg.conversion == pfspec_pkg::CH_LO_S)
            |-> (rec_reg.fields.width <= pfspec_pkg::S_WIDTH_MAX))
        else $error("string record with oversized width");

    // Justification never takes the unused code
    a_justify: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (rec_reg.fields.justify != 2'd3))
        else $error("invalid justification code");
`endif

endmodule
